// ===== hw/rtl/bhpq_pkg.sv =====
package bhpq_pkg;

    localparam int CAPACITY = 256;
    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = 9;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // child indices reach 2*(CAPACITY-1)+2
    localparam int PTR_W    = ADDR_W + 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_HEAP_ORDER = 1'b0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EXT_RD,
        S_EXT_LOAD,
        S_DN_RD,
        S_DN_PICK,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/bhpq_ram.sv =====
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr_b,
    output logic [WIDTH-1:0]                 o_rdata_a,
    output logic [WIDTH-1:0]                 o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hw/rtl/binary_heap_priority_queue.sv =====
// Channel   | Valid        | Stall        | Payload
// ----------+--------------+--------------+---------------------------------------
// input     | i_in_valid   | o_in_stall   | i_command, i_key
// output    | o_out_valid  | i_out_stall  | o_status, o_root_key, o_entry_count
// config    | APB write: psel & penable & pwrite, register at paddr 0
//
// One transaction at a time. Insert climbs one level per read and compare (S_UP_RD,
// S_UP_CMP) and writes the key where it stops. Extract reads the root and the last
// entry, then descends one level per read, pick and compare (S_DN_RD, S_DN_PICK,
// S_DN_CMP) and writes the moved entry where it stops. Refusals go straight to S_DONE.
// The steps are set by the key RAM (registered read, one write port) and the single
// shared key comparator. Synchronous active-low reset clears control and heap_order;
// the key RAM is not cleared. A result held under i_out_stall does not block the
// next input transaction until that one has its own result ready.
module binary_heap_priority_queue
    import bhpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [KEY_W-1:0]     i_key,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [KEY_W-1:0]     o_root_key,
    output logic [ENTRY_W-1:0]   o_entry_count,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_order;
    logic [ADDR_W-1:0]    r_pos, n_pos;
    logic [KEY_W-1:0]     r_val, n_val;
    logic [KEY_W-1:0]     r_root, n_root;
    t_status              r_status, n_status;
    logic [KEY_W-1:0]     r_pick_key, n_pick_key;
    logic [ADDR_W-1:0]    r_pick_pos, n_pick_pos;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [KEY_W-1:0]     r_out_root, n_out_root;
    logic [ENTRY_W-1:0]   r_out_count, n_out_count;

    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [KEY_W-1:0]     w_wdata;
    logic [ADDR_W-1:0]    w_raddr_a, w_raddr_b;
    logic [KEY_W-1:0]     w_rdata_a, w_rdata_b;

    logic [KEY_W-1:0]     w_cmp_a, w_cmp_b;
    logic                 w_beats;
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_full, w_empty;
    logic [ADDR_W-1:0]    w_up;
    logic [PTR_W-1:0]     w_left, w_right, w_cnt_ptr;
    logic                 w_left_out, w_right_in;
    logic [CNT_W+ENTRY_W-1:0] w_cnt_wide;
    logic                 w_cfg_wr;

    bhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign w_in_acc   = (r_state == S_IDLE) && i_in_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count >= CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_up       = (r_pos - ADDR_W'(1)) >> 1;
    assign w_left     = (PTR_W'(r_pos) << 1) + PTR_W'(1);
    assign w_right    = (PTR_W'(r_pos) << 1) + PTR_W'(2);
    assign w_cnt_ptr  = PTR_W'(r_count);
    assign w_left_out = (w_left >= w_cnt_ptr);
    assign w_right_in = (w_right < w_cnt_ptr);
    assign w_cnt_wide = {{ENTRY_W{1'b0}}, r_count};

    // shared comparator: does w_cmp_a strictly beat w_cmp_b in the current order
    always_comb begin
        case (r_state)
            S_UP_CMP: begin
                w_cmp_a = r_val;
                w_cmp_b = w_rdata_a;
            end
            S_DN_PICK: begin
                w_cmp_a = w_rdata_b;
                w_cmp_b = w_rdata_a;
            end
            default: begin
                w_cmp_a = r_pick_key;
                w_cmp_b = r_val;
            end
        endcase
    end

    assign w_beats = r_order ? (w_cmp_a > w_cmp_b) : (w_cmp_a < w_cmp_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == CMD_INSERT) begin
                        n_state = w_full ? S_DONE : S_UP_RD;
                    end else begin
                        n_state = w_empty ? S_DONE : S_EXT_RD;
                    end
                end
            end
            S_UP_RD:    n_state = (r_pos == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP:   n_state = w_beats ? S_UP_RD : S_DONE;
            S_EXT_RD:   n_state = S_EXT_LOAD;
            S_EXT_LOAD: n_state = S_DN_RD;
            S_DN_RD:    n_state = w_left_out ? S_DONE : S_DN_PICK;
            S_DN_PICK:  n_state = S_DN_CMP;
            S_DN_CMP:   n_state = w_beats ? S_DN_RD : S_DONE;
            S_DONE:     n_state = w_out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_val        = r_val;
        n_root       = r_root;
        n_status     = r_status;
        n_pick_key   = r_pick_key;
        n_pick_pos   = r_pick_pos;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_root   = r_out_root;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_waddr      = r_pos;
        w_wdata      = r_val;
        w_raddr_a    = '0;
        w_raddr_b    = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_status = ST_OK;
                    n_root   = '0;
                    if (i_command == CMD_INSERT) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_val   = i_key;
                            n_pos   = r_count[ADDR_W-1:0];
                            n_count = r_count + CNT_W'(1);
                        end
                    end else begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we = 1'b1;
                end else begin
                    w_raddr_a = w_up;
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (w_beats) begin
                    // move the parent down, keep climbing
                    w_wdata = w_rdata_a;
                    n_pos   = w_up;
                end
            end
            S_EXT_RD: begin
                w_raddr_a = '0;
                w_raddr_b = r_count[ADDR_W-1:0];
            end
            S_EXT_LOAD: begin
                n_root = w_rdata_a;
                n_val  = w_rdata_b;
                n_pos  = '0;
            end
            S_DN_RD: begin
                if (w_left_out) begin
                    w_we = 1'b1;
                end else begin
                    w_raddr_a = w_left[ADDR_W-1:0];
                    w_raddr_b = w_right[ADDR_W-1:0];
                end
            end
            S_DN_PICK: begin
                // equal children go left
                if (w_right_in && w_beats) begin
                    n_pick_key = w_rdata_b;
                    n_pick_pos = w_right[ADDR_W-1:0];
                end else begin
                    n_pick_key = w_rdata_a;
                    n_pick_pos = w_left[ADDR_W-1:0];
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_beats) begin
                    w_wdata = r_pick_key;
                    n_pos   = r_pick_pos;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_root   = r_root;
                    n_out_count  = w_cnt_wide[ENTRY_W-1:0];
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HEAP_ORDER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_order     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                r_order <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_val        <= n_val;
        r_root       <= n_root;
        r_status     <= n_status;
        r_pick_key   <= n_pick_key;
        r_pick_pos   <= n_pick_pos;
        r_out_status <= n_out_status;
        r_out_root   <= n_out_root;
        r_out_count  <= n_out_count;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_root_key    = r_out_root;
    assign o_entry_count = r_out_count;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_HEAP_ORDER) ? {{(PDATA_W-1){1'b0}}, r_order}
                                                        : '0;

endmodule

// ===== hw/rtl/bhpq_chk.sv =====
module bhpq_chk
    import bhpq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_stall,
    input  logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  logic [1:0]           o_status,
    input  logic [KEY_W-1:0]     o_root_key,
    input  logic [ENTRY_W-1:0]   o_entry_count
);

    // a waiting result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // refused operations return a zero key
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_root_key == '0))
        else $error("refused operation carries a nonzero key");

    // the input stalls in the cycle after every accepted transaction
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transaction");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= ENTRY_W'(CAPACITY)))
        else $error("entry count beyond capacity");

endmodule

bind binary_heap_priority_queue bhpq_chk u_bhpq_chk (.*);

// ===== sim/binary_heap_priority_queue_tb.sv =====
module binary_heap_priority_queue_tb;
    import bhpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status              status;
        logic [KEY_W-1:0]     root_key;
        logic [ENTRY_W-1:0]   entry_count;
    } t_heap_outcome;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    logic                 i_command     = CMD_INSERT;
    logic [KEY_W-1:0]     i_key         = '0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic [1:0]           o_status;
    logic [KEY_W-1:0]     o_root_key;
    logic [ENTRY_W-1:0]   o_entry_count;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [PADDR_W-1:0]   paddr         = '0;
    logic [PDATA_W-1:0]   pwdata        = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // heap mirror, updated at each accepted input transaction
    logic [KEY_W-1:0]     heap_keys [CAPACITY];
    int unsigned          heap_size      = 0;
    logic                 heap_max_first = 1'b0;

    t_heap_outcome        expected_outcomes [$];
    int                   error_count    = 0;
    int                   in_gap_pct     = 0;
    int                   out_stall_pct  = 0;

    binary_heap_priority_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_key         (i_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_root_key    (o_root_key),
        .o_entry_count (o_entry_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic bit outranks(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        return heap_max_first ? (a > b) : (a < b);
    endfunction

    function automatic t_heap_outcome predict_heap_op(input logic cmd,
                                                      input logic [KEY_W-1:0] key);
        t_heap_outcome    res;
        int unsigned      pos;
        int unsigned      parent;
        int unsigned      left;
        int unsigned      right;
        int unsigned      pick;
        logic [KEY_W-1:0] tmp;
        bit               moving;
        res.status   = ST_OK;
        res.root_key = '0;
        if (cmd == CMD_INSERT) begin
            if (heap_size >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos = heap_size;
                heap_keys[pos] = key;
                heap_size++;
                moving = 1'b1;
                while (moving && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (outranks(heap_keys[pos], heap_keys[parent])) begin
                        tmp               = heap_keys[pos];
                        heap_keys[pos]    = heap_keys[parent];
                        heap_keys[parent] = tmp;
                        pos = parent;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else begin
            if (heap_size == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.root_key = heap_keys[0];
                heap_size--;
                heap_keys[0] = heap_keys[heap_size];
                // follow the moved entry down; equal children go left
                pos = 0;
                moving = 1'b1;
                while (moving) begin
                    left  = 2 * pos + 1;
                    right = 2 * pos + 2;
                    if (left >= heap_size) begin
                        moving = 1'b0;
                    end else begin
                        pick = left;
                        if (right < heap_size && outranks(heap_keys[right], heap_keys[left]))
                            pick = right;
                        if (outranks(heap_keys[pick], heap_keys[pos])) begin
                            tmp             = heap_keys[pos];
                            heap_keys[pos]  = heap_keys[pick];
                            heap_keys[pick] = tmp;
                            pos = pick;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                end
            end
        end
        res.entry_count = heap_size[ENTRY_W-1:0];
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1:    return KEY_W'($urandom_range(0, 7));
            2:       return $urandom_range(0, 1) ? '1 : '0;
            3:       return 32'hFFFF_FFF0 | KEY_W'($urandom_range(0, 15));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Valid stays high from one transaction to the next unless a gap is drawn.
    task automatic push_heap_command(input logic cmd, input logic [KEY_W-1:0] key);
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall);
        expected_outcomes.push_back(predict_heap_op(cmd, key));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                                output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_HEAP_ORDER, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_heap_order_reg();
        logic [PDATA_W-1:0] rd;
        apb_transfer(1'b0, '0, rd);
        if (rd[0] !== heap_max_first)
            flag_error($sformatf("heap_order read %0b, want %0b", rd[0], heap_max_first));
    endtask

    task automatic set_heap_order(input logic max_first);
        logic [PDATA_W-1:0] rd;
        wait_idle();
        apb_transfer(1'b1, PDATA_W'(max_first), rd);
        heap_max_first = max_first;
        check_heap_order_reg();
    endtask

    always @(posedge i_clk) begin : result_check
        t_heap_outcome want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_outcomes.size() == 0) begin
                flag_error($sformatf("unexpected result status=%0d key=%h count=%0d",
                                     o_status, o_root_key, o_entry_count));
            end else begin
                want = expected_outcomes.pop_front();
                if (o_status !== want.status || o_root_key !== want.root_key ||
                    o_entry_count !== want.entry_count)
                    flag_error($sformatf({"got status=%0d key=%h count=%0d, ",
                                          "want status=%0d key=%h count=%0d"},
                                         o_status, o_root_key, o_entry_count,
                                         want.status, want.root_key, want.entry_count));
            end
        end
    end

    // receiver side: random stall bursts
    always begin : out_stall_gen
        int n;
        @(posedge i_clk);
        if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
            n = $urandom_range(1, 18);
            i_out_stall <= 1'b1;
            repeat (n) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // Default order after reset, empty extract, extremes.
    task automatic test_min_first_basics();
        check_heap_order_reg();
        push_heap_command(CMD_EXTRACT, 32'hDEAD_BEEF);
        push_heap_command(CMD_INSERT, 32'hFFFF_FFFF);
        push_heap_command(CMD_INSERT, 32'h0000_0000);
        push_heap_command(CMD_INSERT, 32'd9);
        push_heap_command(CMD_INSERT, 32'd9);
        push_heap_command(CMD_INSERT, 32'd9);
        push_heap_command(CMD_INSERT, 32'd4);
        repeat (7) push_heap_command(CMD_EXTRACT, pick_key());
    endtask

    // Equal keys in max-first order, then an order flip with keys still held.
    task automatic test_max_first_and_flip();
        set_heap_order(1'b1);
        push_heap_command(CMD_INSERT, 32'd0);
        push_heap_command(CMD_INSERT, 32'd0);
        push_heap_command(CMD_INSERT, 32'd0);
        push_heap_command(CMD_INSERT, 32'hFFFF_FFFF);
        push_heap_command(CMD_INSERT, 32'd2);
        push_heap_command(CMD_INSERT, 32'd2);
        repeat (2) push_heap_command(CMD_EXTRACT, '0);
        set_heap_order(1'b0);
        repeat (5) push_heap_command(CMD_EXTRACT, '1);
    endtask

    // Fill to capacity, refuse, partly drain and refill, then drain past empty.
    task automatic test_fill_to_capacity();
        set_heap_order(1'($urandom_range(0, 1)));
        in_gap_pct    = 15;
        out_stall_pct = 5;
        while (heap_size < CAPACITY) push_heap_command(CMD_INSERT, KEY_W'($urandom));
        push_heap_command(CMD_INSERT, '0);
        push_heap_command(CMD_INSERT, '1);
        repeat (20) push_heap_command(CMD_EXTRACT, pick_key());
        repeat (20) push_heap_command(CMD_INSERT, pick_key());
        push_heap_command(CMD_INSERT, pick_key());
        while (heap_size > 0) push_heap_command(CMD_EXTRACT, pick_key());
        push_heap_command(CMD_EXTRACT, pick_key());
    endtask

    task automatic test_random_traffic();
        int insert_pct [8] = '{80, 50, 25, 70, 40, 60, 30, 50};
        int seg;
        for (seg = 0; seg < 8; seg++) begin
            if (seg < 2)
                set_heap_order(seg[0]);
            else if ($urandom_range(0, 1))
                set_heap_order(1'($urandom_range(0, 1)));
            if (seg == 7 || seg % 3 == 2) begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end else begin
                in_gap_pct    = $urandom_range(10, 40);
                out_stall_pct = $urandom_range(2, 15);
            end
            repeat (30) begin
                if ($urandom_range(0, 99) < insert_pct[seg])
                    push_heap_command(CMD_INSERT, pick_key());
                else
                    push_heap_command(CMD_EXTRACT, pick_key());
            end
        end
    endtask

    initial begin
        in_gap_pct    = 20;
        out_stall_pct = 8;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_min_first_basics();
        test_max_first_and_flip();
        test_fill_to_capacity();
        test_random_traffic();
        wait_idle();
        if (error_count == 0)
            $display("binary_heap_priority_queue_tb OK");
        else
            $display("binary_heap_priority_queue_tb NOT OK");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("binary_heap_priority_queue_tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bhpq_pkg.sv
hw/rtl/bhpq_ram.sv
hw/rtl/binary_heap_priority_queue.sv
hw/rtl/bhpq_chk.sv
sim/binary_heap_priority_queue_tb.sv
